>>> rtl/mbma_pkg.sv
package mbma_pkg;

  // fixed field widths of the item and result beats
  localparam int OPCODE_W      = 1;
  localparam int TAGLINE_W     = 4;
  localparam int BLOCK_INDEX_W = 7;
  localparam int COMMAND_W     = 1;
  localparam int DISK_W        = 4;
  localparam int DISK_BLOCK_W  = 12;
  localparam int STATUS_W      = 2;

  // configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam int LIMIT_W = 5;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;
  // register select is paddr[2]
  localparam logic REG_TAGLINE_LIMIT = 1'b0;

  // default geometry
  localparam int MAX_TAGLINES_DEF       = 16;
  localparam int BLOCKS_PER_TAGLINE_DEF = 128;
  localparam int DISK_BLOCKS_DEF        = 4096;
  localparam int PRIMARY_DISKS_DEF      = 8;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_UNMAPPED = 2'd1,
    ST_FULL     = 2'd2,
    ST_RANGE    = 2'd3
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic accept;
    logic eval;
    logic emit2;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic in_fire;
    logic out_free;
    logic two;
  } ctl_sts_t;

endpackage

>>> rtl/mbma_req_if.sv
interface mbma_req_if;
  import mbma_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OPCODE_W-1:0]      opcode;
  logic [TAGLINE_W-1:0]     tagline;
  logic [BLOCK_INDEX_W-1:0] block_index;

  modport source (output valid, output opcode, output tagline, output block_index,
                  input ready);
  modport sink (input valid, input opcode, input tagline, input block_index,
                output ready);
endinterface

>>> rtl/mbma_rsp_if.sv
interface mbma_rsp_if;
  import mbma_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [COMMAND_W-1:0]    command;
  logic [DISK_W-1:0]       disk;
  logic [DISK_BLOCK_W-1:0] disk_block;
  logic [STATUS_W-1:0]     status;
  logic                    last;

  modport source (output valid, output command, output disk, output disk_block,
                  output status, output last, input ready);
  modport sink (input valid, input command, input disk, input disk_block,
                input status, input last, output ready);
endinterface

>>> rtl/mirrored_block_map_allocator_core.sv
// an accepted item and its map entry are registered at accept; the controller
// then steps evaluate, which loads the output register once it is free, and
// for a write not rejected a mirror beat, before it accepts the next item
// reset: allocator at disk 0 block 0, tagline_limit 16; the map store is then
// cleared one entry a cycle, all MAX_TAGLINES*BLOCKS_PER_TAGLINE entries (2048
// by default), before the first item is taken
module mirrored_block_map_allocator_core #(
  parameter int MAX_TAGLINES       = mbma_pkg::MAX_TAGLINES_DEF,
  parameter int BLOCKS_PER_TAGLINE = mbma_pkg::BLOCKS_PER_TAGLINE_DEF,
  parameter int DISK_BLOCKS        = mbma_pkg::DISK_BLOCKS_DEF,
  parameter int PRIMARY_DISKS      = mbma_pkg::PRIMARY_DISKS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  mbma_req_if.sink                     req_i,
  mbma_rsp_if.source                   rsp_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mbma_pkg::PADDR_W-1:0] paddr,
  input  logic [mbma_pkg::PDATA_W-1:0] pwdata,
  output logic [mbma_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);
  import mbma_pkg::*;

  // tagline_limit register, the only one, at byte address 0
  logic [LIMIT_W-1:0] tagline_limit_q;
  logic               reg_sel;
  logic               cfg_wr;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  // paddr[2] selects the register word, low bits are byte lanes
  assign reg_sel = (paddr[2] == REG_TAGLINE_LIMIT);
  assign pready  = 1'b1;
  // write completes in the access phase
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tagline_limit_q <= LIMIT_RESET;
    end else if (cfg_wr && reg_sel) begin
      tagline_limit_q <= pwdata[LIMIT_W-1:0];
    end
  end

  // reads of unused words return zero
  assign prdata = reg_sel ? PDATA_W'(tagline_limit_q) : '0;

  // sequencer: clear pass, accept, evaluate, optional mirror beat
  mbma_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // map store, allocator and output register
  mbma_datapath #(
    .MAX_TAGLINES       (MAX_TAGLINES),
    .BLOCKS_PER_TAGLINE (BLOCKS_PER_TAGLINE),
    .DISK_BLOCKS        (DISK_BLOCKS),
    .PRIMARY_DISKS      (PRIMARY_DISKS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .tagline_limit_i (tagline_limit_q),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .req             (req_i),
    .rsp             (rsp_o)
  );

endmodule

>>> rtl/mbma_ctrl.sv
module mbma_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mbma_pkg::ctl_sts_t sts_i,
  output mbma_pkg::ctl_cmd_t cmd_o
);
  import mbma_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_EVAL  = 4'b0100,
    S_EMIT2 = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        cmd_o.accept = 1'b1;
        if (sts_i.in_fire) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        if (sts_i.out_free) begin
          state_d = sts_i.two ? S_EMIT2 : S_IDLE;
        end
      end
      S_EMIT2: begin
        cmd_o.emit2 = 1'b1;
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/mbma_datapath.sv
module mbma_datapath #(
  parameter int MAX_TAGLINES       = mbma_pkg::MAX_TAGLINES_DEF,
  parameter int BLOCKS_PER_TAGLINE = mbma_pkg::BLOCKS_PER_TAGLINE_DEF,
  parameter int DISK_BLOCKS        = mbma_pkg::DISK_BLOCKS_DEF,
  parameter int PRIMARY_DISKS      = mbma_pkg::PRIMARY_DISKS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [mbma_pkg::LIMIT_W-1:0]   tagline_limit_i,
  input  mbma_pkg::ctl_cmd_t             cmd_i,
  output mbma_pkg::ctl_sts_t             sts_o,
  mbma_req_if.sink                       req,
  mbma_rsp_if.source                     rsp
);
  import mbma_pkg::*;

  localparam int MAP_DEPTH = MAX_TAGLINES * BLOCKS_PER_TAGLINE;
  localparam int AW  = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
  localparam int DW  = (PRIMARY_DISKS > 1) ? $clog2(PRIMARY_DISKS) : 1;
  localparam int NDW = $clog2(PRIMARY_DISKS + 1);
  localparam int BW  = $clog2(DISK_BLOCKS);
  localparam int EW  = 1 + DW + BW;

  // map store: valid, primary disk, disk block
  logic [EW-1:0] map_mem [MAP_DEPTH];

  logic          in_fire, eval_fire, emit2_fire, out_free;
  logic [AW-1:0] addr_in;
  logic          range_in;

  logic          op_q, range_q;
  logic [AW-1:0] addr_q;
  logic [EW-1:0] rd_q;
  logic [AW-1:0] clr_cnt_q;

  logic [NDW-1:0] next_disk_q, next_disk_d;
  logic [BW-1:0]  next_block_q, next_block_d;

  logic          map_valid;
  logic [DW-1:0] map_disk, eff_disk;
  logic [BW-1:0] map_blk, eff_blk;
  logic          full, alloc, alloc_fire, two;

  logic                    r0_cmd, r0_last;
  logic [DISK_W-1:0]       r0_disk;
  logic [DISK_BLOCK_W-1:0] r0_blk;
  status_e                 r0_status;

  logic [DISK_W-1:0]       mir_disk_q;
  logic [DISK_BLOCK_W-1:0] mir_blk_q;

  logic                    out_valid_q;
  logic                    out_cmd_q, out_last_q;
  logic [DISK_W-1:0]       out_disk_q;
  logic [DISK_BLOCK_W-1:0] out_blk_q;
  logic [STATUS_W-1:0]     out_status_q;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;

  assign req.ready  = cmd_i.accept;
  assign in_fire    = req.valid & cmd_i.accept;
  assign out_free   = !out_valid_q || rsp.ready;
  assign eval_fire  = cmd_i.eval & out_free;
  assign emit2_fire = cmd_i.emit2 & out_free;

  assign addr_in  = AW'(32'(req.tagline) * 32'(BLOCKS_PER_TAGLINE) + 32'(req.block_index));
  assign range_in = ({1'b0, req.tagline} >= tagline_limit_i)
                 || (32'(req.tagline) >= 32'(MAX_TAGLINES))
                 || (32'(req.block_index) >= 32'(BLOCKS_PER_TAGLINE));

  // item capture
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q    <= req.opcode;
      range_q <= range_in;
      addr_q  <= addr_in;
    end
  end

  // registered map read at the accept edge
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rd_q <= map_mem[addr_in];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      map_mem[mem_waddr] <= mem_wdata;
    end
  end

  assign map_valid = rd_q[EW-1];
  assign map_disk  = rd_q[BW +: DW];
  assign map_blk   = rd_q[BW-1:0];
  assign full      = (next_disk_q == NDW'(PRIMARY_DISKS));

  always_comb begin
    alloc     = 1'b0;
    two       = 1'b0;
    eff_disk  = map_disk;
    eff_blk   = map_blk;
    r0_cmd    = op_q;
    r0_disk   = '0;
    r0_blk    = '0;
    r0_status = ST_OK;
    r0_last   = 1'b1;
    if (range_q) begin
      r0_status = ST_RANGE;
    end else if (op_q == OP_READ) begin
      if (!map_valid) begin
        r0_status = ST_UNMAPPED;
      end else begin
        r0_disk = DISK_W'(map_disk);
        r0_blk  = DISK_BLOCK_W'(map_blk);
      end
    end else if (!map_valid && full) begin
      r0_status = ST_FULL;
    end else begin
      if (!map_valid) begin
        alloc    = 1'b1;
        eff_disk = DW'(next_disk_q);
        eff_blk  = next_block_q;
      end
      two     = 1'b1;
      r0_disk = DISK_W'(eff_disk);
      r0_blk  = DISK_BLOCK_W'(eff_blk);
      r0_last = 1'b0;
    end
  end

  assign alloc_fire = alloc & eval_fire;

  // allocator: next slot, wraps to block zero of the next primary disk
  always_comb begin
    next_disk_d  = next_disk_q;
    next_block_d = next_block_q;
    if (alloc_fire) begin
      if (next_block_q == BW'(DISK_BLOCKS - 1)) begin
        next_block_d = '0;
        next_disk_d  = next_disk_q + NDW'(1);
      end else begin
        next_block_d = next_block_q + BW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_disk_q  <= '0;
      next_block_q <= '0;
      clr_cnt_q    <= '0;
    end else begin
      next_disk_q  <= next_disk_d;
      next_block_q <= next_block_d;
      if (cmd_i.clear) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
      end
    end
  end

  assign mem_we    = cmd_i.clear | alloc_fire;
  assign mem_waddr = cmd_i.clear ? clr_cnt_q : addr_q;
  assign mem_wdata = cmd_i.clear ? '0 : {1'b1, eff_disk, eff_blk};

  // mirror beat follows the primary
  always_ff @(posedge clk_i) begin
    if (eval_fire) begin
      mir_disk_q <= DISK_W'(32'(eff_disk) + 32'(PRIMARY_DISKS));
      mir_blk_q  <= DISK_BLOCK_W'(eff_blk);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (eval_fire || emit2_fire) begin
      out_valid_q <= 1'b1;
    end else if (rsp.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (eval_fire) begin
      out_cmd_q    <= r0_cmd;
      out_disk_q   <= r0_disk;
      out_blk_q    <= r0_blk;
      out_status_q <= r0_status;
      out_last_q   <= r0_last;
    end else if (emit2_fire) begin
      out_cmd_q    <= OP_WRITE;
      out_disk_q   <= mir_disk_q;
      out_blk_q    <= mir_blk_q;
      out_status_q <= ST_OK;
      out_last_q   <= 1'b1;
    end
  end

  assign rsp.valid      = out_valid_q;
  assign rsp.command    = out_cmd_q;
  assign rsp.disk       = out_disk_q;
  assign rsp.disk_block = out_blk_q;
  assign rsp.status     = out_status_q;
  assign rsp.last       = out_last_q;

  assign sts_o.clear_last = cmd_i.clear && (clr_cnt_q == AW'(MAP_DEPTH - 1));
  assign sts_o.in_fire    = in_fire;
  assign sts_o.out_free   = out_free;
  assign sts_o.two        = two;

`ifndef SYNTHESIS
  a_alloc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_disk_q <= NDW'(PRIMARY_DISKS))
    else $error("allocator ran past the last primary disk");

  a_alloc_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alloc_fire |=> (next_disk_q != $past(next_disk_q))
                || (next_block_q != $past(next_block_q)))
    else $error("allocation did not advance the allocator");

  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |-> !req.ready)
    else $error("item accepted during map clearing");

  a_primary_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (eval_fire && two) |=> (out_valid_q && !out_last_q && out_cmd_q == OP_WRITE))
    else $error("primary write beat malformed");
`endif

endmodule
